// ===== hdl/gcfc_pkg.sv =====
// ---------------------------------------------------------------------------
// gcfc_pkg
// Shared constants, state encoding and control bundles for the gap-cluster
// frequency classifier.
// ---------------------------------------------------------------------------
package gcfc_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int VALUE_W       = 16;
    localparam int OUT_COUNT_W   = 6;
    localparam int APB_ADDR_W    = 1;
    localparam int APB_DATA_W    = 32;

    localparam logic [VALUE_W-1:0]    GAP_LIMIT_RESET = 16'd100;
    localparam logic [APB_ADDR_W-1:0] ADDR_GAP_LIMIT  = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIST_RD,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_CLOSE,
        ST_MULT,
        ST_DONE
    } gcfc_state_t;

    typedef struct packed {
        logic start;
        logic hist_wr;
        logic rd_issue;
        logic skip_old;
        logic emit_x;
        logic emit_data;
        logic close;
        logic mult;
        logic load_out;
    } gcfc_cmd_t;

    typedef struct packed {
        logic read_done;
        logic skip_hit;
        logic insert_hit;
        logic x_pending;
        logic out_busy;
    } gcfc_status_t;

endpackage

// ===== hdl/gcfc_regs.sv =====
// ---------------------------------------------------------------------------
// gcfc_regs
// APB register file holding the cluster gap limit.
// ---------------------------------------------------------------------------
module gcfc_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gcfc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gcfc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gcfc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [gcfc_pkg::VALUE_W-1:0]     gap_limit
);
    import gcfc_pkg::*;

    logic [VALUE_W-1:0] gap_limit_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg <= GAP_LIMIT_RESET;
        end
        else if (wr_en && (paddr == ADDR_GAP_LIMIT))
        begin
            gap_limit_reg <= pwdata[VALUE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_GAP_LIMIT)
        begin
            prdata = APB_DATA_W'(gap_limit_reg);
        end
    end

    assign gap_limit = gap_limit_reg;

endmodule

// ===== hdl/gcfc_ctrl.sv =====
// ---------------------------------------------------------------------------
// gcfc_ctrl
// Sequencer: history update, sorted merge scan, frequency check, result load.
// ---------------------------------------------------------------------------
module gcfc_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  gcfc_pkg::gcfc_status_t  status,
    output gcfc_pkg::gcfc_cmd_t     cmd
);
    import gcfc_pkg::*;

    gcfc_state_t state_reg;
    gcfc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_HIST_RD;
                end
            end
            ST_HIST_RD:
            begin
                cmd.hist_wr = 1'b1;
                state_next  = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                if (!status.read_done)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_SCAN_CMP;
                end
                else
                begin
                    cmd.emit_x = status.x_pending;
                    state_next = ST_CLOSE;
                end
            end
            ST_SCAN_CMP:
            begin
                if (status.skip_hit)
                begin
                    cmd.skip_old = 1'b1;
                    state_next   = ST_SCAN_RD;
                end
                else if (status.insert_hit)
                begin
                    cmd.emit_x = 1'b1;
                end
                else
                begin
                    cmd.emit_data = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_HIST_RD))
        else $error("accepted transaction did not start history update");

    a_insert_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_CMP && !status.skip_hit && status.insert_hit)
        |=> (!status.insert_hit && !status.x_pending))
        else $error("new value inserted more than once");

endmodule

// ===== hdl/gcfc_dp.sv =====
// ---------------------------------------------------------------------------
// gcfc_dp
// Datapath: history ring, double-banked sorted store, cluster scan and
// result register.
// ---------------------------------------------------------------------------
module gcfc_dp
#(
    parameter int DEPTH = gcfc_pkg::DEPTH_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  gcfc_pkg::gcfc_cmd_t              cmd,
    output gcfc_pkg::gcfc_status_t           status,
    input  logic [gcfc_pkg::VALUE_W-1:0]     gap_limit,
    input  logic [gcfc_pkg::VALUE_W-1:0]     sample_value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             is_frequent,
    output logic [gcfc_pkg::OUT_COUNT_W-1:0] cluster_total,
    output logic [gcfc_pkg::OUT_COUNT_W-1:0] member_count,
    output logic [gcfc_pkg::OUT_COUNT_W-1:0] fill_level
);
    import gcfc_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int PW = 2 * CW;

    logic [VALUE_W-1:0] hist_mem [DEPTH];
    logic [VALUE_W-1:0] srt_mem  [2][DEPTH];

    logic [VALUE_W-1:0] hist_q;
    logic [VALUE_W-1:0] srt_q;
    logic [VALUE_W-1:0] x_reg;
    logic [VALUE_W-1:0] old_reg;
    logic [VALUE_W-1:0] prev_reg;

    logic [IW-1:0]      slot_reg;
    logic [IW-1:0]      slot_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      n_reg;
    logic               full_reg;
    logic               bank_reg;

    logic [CW-1:0]      r_reg;
    logic [CW-1:0]      w_reg;
    logic               inserted_reg;
    logic               removed_reg;

    logic [CW-1:0]      clusters_reg;
    logic [CW-1:0]      run_reg;
    logic [CW-1:0]      members_reg;
    logic               has_x_reg;
    logic [PW-1:0]      prod_reg;

    logic               out_valid_reg;
    logic               frequent_out_reg;
    logic [CW-1:0]      clusters_out_reg;
    logic [CW-1:0]      members_out_reg;
    logic [CW-1:0]      fill_out_reg;

    logic               emit;
    logic [VALUE_W-1:0] emit_val;
    logic [VALUE_W-1:0] gap;
    logic               brk;
    logic               eq_x;
    logic [PW:0]        freq_sum;
    logic               frequent;

    assign slot_next = (slot_reg == IW'(DEPTH - 1)) ? '0 : slot_reg + 1'b1;

    assign emit     = cmd.emit_x || cmd.emit_data;
    assign emit_val = cmd.emit_x ? x_reg : srt_q;
    assign gap      = emit_val - prev_reg;
    assign brk      = (w_reg == '0) || (gap > gap_limit);
    assign eq_x     = (emit_val == x_reg);
    assign freq_sum = {1'b0, prod_reg} + (PW + 1)'(clusters_reg);
    assign frequent = freq_sum > (PW + 1)'(count_reg);

    assign status.read_done  = (r_reg == n_reg);
    assign status.skip_hit   = full_reg && !removed_reg && (srt_q == old_reg);
    assign status.insert_hit = !inserted_reg && (x_reg <= srt_q);
    assign status.x_pending  = !inserted_reg;
    assign status.out_busy   = out_valid_reg && out_stall;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            hist_q <= hist_mem[slot_reg];
        end
        if (cmd.hist_wr)
        begin
            hist_mem[slot_reg] <= x_reg;
        end
        if (cmd.rd_issue)
        begin
            srt_q <= srt_mem[bank_reg][r_reg[IW-1:0]];
        end
        if (emit)
        begin
            srt_mem[~bank_reg][w_reg[IW-1:0]] <= emit_val;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            count_reg     <= '0;
            n_reg         <= '0;
            full_reg      <= 1'b0;
            bank_reg      <= 1'b0;
            r_reg         <= '0;
            w_reg         <= '0;
            inserted_reg  <= 1'b0;
            removed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                n_reg        <= count_reg;
                full_reg     <= (count_reg == CW'(DEPTH));
                if (count_reg != CW'(DEPTH))
                begin
                    count_reg <= count_reg + 1'b1;
                end
                r_reg        <= '0;
                w_reg        <= '0;
                inserted_reg <= 1'b0;
                removed_reg  <= 1'b0;
            end
            if (cmd.hist_wr)
            begin
                slot_reg <= slot_next;
            end
            if (cmd.skip_old)
            begin
                removed_reg <= 1'b1;
            end
            if (cmd.skip_old || cmd.emit_data)
            begin
                r_reg <= r_reg + 1'b1;
            end
            if (cmd.emit_x)
            begin
                inserted_reg <= 1'b1;
            end
            if (emit)
            begin
                w_reg <= w_reg + 1'b1;
            end
            if (cmd.close)
            begin
                bank_reg <= ~bank_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg        <= sample_value;
            clusters_reg <= '0;
            run_reg      <= '0;
            members_reg  <= '0;
            has_x_reg    <= 1'b0;
        end
        if (cmd.hist_wr)
        begin
            old_reg <= hist_q;
        end
        if (emit)
        begin
            prev_reg <= emit_val;
            if (brk)
            begin
                if (has_x_reg)
                begin
                    members_reg <= run_reg;
                end
                clusters_reg <= clusters_reg + 1'b1;
                run_reg      <= CW'(1);
                has_x_reg    <= eq_x;
            end
            else
            begin
                run_reg   <= run_reg + 1'b1;
                has_x_reg <= has_x_reg || eq_x;
            end
        end
        if (cmd.close && has_x_reg)
        begin
            members_reg <= run_reg;
        end
        if (cmd.mult)
        begin
            prod_reg <= members_reg * clusters_reg;
        end
        if (cmd.load_out)
        begin
            frequent_out_reg <= frequent;
            clusters_out_reg <= clusters_reg;
            members_out_reg  <= members_reg;
            fill_out_reg     <= count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_frequent   = frequent_out_reg;
    assign cluster_total = OUT_COUNT_W'(clusters_out_reg);
    assign member_count  = OUT_COUNT_W'(members_out_reg);
    assign fill_level    = OUT_COUNT_W'(fill_out_reg);

    a_merge_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |-> (w_reg == count_reg))
        else $error("merged store length differs from fill count");

    a_merge_lead: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, w_reg} <= ({1'b0, r_reg} + 1'b1)))
        else $error("write index ran ahead of read index");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (members_out_reg != '0 && members_out_reg <= fill_out_reg
                           && clusters_out_reg != '0 && clusters_out_reg <= fill_out_reg))
        else $error("result counts out of range");

endmodule

// ===== hdl/gap_cluster_frequency_classifier.sv =====
// ---------------------------------------------------------------------------
// gap_cluster_frequency_classifier
// Clusters the most recent DEPTH timing values by sorted neighbor gap and
// classifies the cluster of each new value.
//
// Usage:
//   Input channel in_valid/in_stall carries sample_value; output channel
//   out_valid/out_stall carries is_frequent, cluster_total, member_count and
//   fill_level, one result transaction per input transaction.
//   gap_limit sits at APB byte address 0 and is to be written only while idle;
//   the block itself does not enforce this. Each transaction merges the new
//   value into a sorted copy of the history held in a two-bank store, reading
//   one stored entry at a time through the single read port. The next input is
//   taken as soon as the result is loaded into the output register; a stalled
//   result holds there and blocks only the next load. Reset empties the
//   history, sets gap_limit to 100 and drops any pending result; no clearing
//   pass is needed.
// ---------------------------------------------------------------------------
module gap_cluster_frequency_classifier
#(
    parameter int DEPTH = gcfc_pkg::DEPTH_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gcfc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gcfc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gcfc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [gcfc_pkg::VALUE_W-1:0]     sample_value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             is_frequent,
    output logic [gcfc_pkg::OUT_COUNT_W-1:0] cluster_total,
    output logic [gcfc_pkg::OUT_COUNT_W-1:0] member_count,
    output logic [gcfc_pkg::OUT_COUNT_W-1:0] fill_level
);
    import gcfc_pkg::*;

    logic [VALUE_W-1:0] gap_limit;
    gcfc_cmd_t          cmd;
    gcfc_status_t       status;

    gcfc_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .gap_limit (gap_limit)
    );

    gcfc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gcfc_dp
    #(
        .DEPTH (DEPTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .gap_limit     (gap_limit),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_frequent   (is_frequent),
        .cluster_total (cluster_total),
        .member_count  (member_count),
        .fill_level    (fill_level)
    );

endmodule

// ===== verif/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gap-cluster frequency classifier. A local
// predictor keeps its own history ring and gap limit, sorts the stored values
// and clusters them by neighbor gap on every accepted input transaction.
// Every result transaction is compared field by field with the oldest
// prediction. Directed tests cover register access, value extremes, gap
// limits of zero and maximum and a long output hold-off. Random phases
// follow, with clustered, repeated and scattered values under several gap
// limits and, in all but the last phase, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_top;

    import gcfc_pkg::*;

    localparam int DEPTH         = DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        logic                   frequent;
        logic [OUT_COUNT_W-1:0] clusters;
        logic [OUT_COUNT_W-1:0] members;
        logic [OUT_COUNT_W-1:0] fill;
    } verdict_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr        = '0;
    logic [APB_DATA_W-1:0]  pwdata       = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic [VALUE_W-1:0]     sample_value = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic                   is_frequent;
    logic [OUT_COUNT_W-1:0] cluster_total;
    logic [OUT_COUNT_W-1:0] member_count;
    logic [OUT_COUNT_W-1:0] fill_level;

    logic [VALUE_W-1:0] history_mem [DEPTH];
    int                 slot_ptr     = 0;
    int                 stored_count = 0;
    logic [VALUE_W-1:0] gap_shadow   = GAP_LIMIT_RESET;

    verdict_t pending_verdicts [$];
    int       fail_count    = 0;
    bit       quiet_mode    = 1'b0;
    int       hold_request  = 0;
    int       hold_left     = 0;
    int       burst_left    = 0;

    gap_cluster_frequency_classifier u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_frequent   (is_frequent),
        .cluster_total (cluster_total),
        .member_count  (member_count),
        .fill_level    (fill_level)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic verdict_t classify_sample(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] ordered [DEPTH];
        logic [VALUE_W-1:0] key;
        int                 j;
        int                 clusters;
        int                 members;
        int                 run;
        bit                 holds_new;
        verdict_t           r;
        clusters  = 0;
        members   = 0;
        run       = 0;
        holds_new = 1'b0;
        history_mem[slot_ptr] = v;
        slot_ptr = (slot_ptr + 1) % DEPTH;
        if (stored_count < DEPTH)
            stored_count++;
        for (int i = 0; i < stored_count; i++)
            ordered[i] = history_mem[i];
        for (int i = 1; i < stored_count; i++)
        begin
            key = ordered[i];
            j   = i;
            while (j > 0 && ordered[j-1] > key)
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = key;
        end
        for (int i = 0; i < stored_count; i++)
        begin
            if (i == 0 || int'(ordered[i]) - int'(ordered[i-1]) > int'(gap_shadow))
            begin
                if (holds_new)
                    members = run;
                clusters++;
                run       = 0;
                holds_new = 1'b0;
            end
            run++;
            if (ordered[i] == v)
                holds_new = 1'b1;
        end
        if (holds_new)
            members = run;
        r.frequent = (clusters != 0 && members >= stored_count / clusters);
        r.clusters = clusters[OUT_COUNT_W-1:0];
        r.members  = members[OUT_COUNT_W-1:0];
        r.fill     = stored_count[OUT_COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            pending_verdicts.push_back(classify_sample(sample_value));
    end

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result transaction with no prediction waiting");
                fail_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                check_field("is_frequent", want.frequent, is_frequent);
                check_field("cluster_total", want.clusters, cluster_total);
                check_field("member_count", want.members, member_count);
                check_field("fill_level", want.fill, fill_level);
            end
        end
    end

    always @(posedge clk)
    begin : stall_gen
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (quiet_mode || !rst_n)
        begin
            burst_left = 0;
            out_stall <= 1'b0;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            burst_left = $urandom_range(1, 17) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_sample(input logic [VALUE_W-1:0] v);
        int idle_len;
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            idle_len = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (idle_len) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_GAP_LIMIT;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (wr)
            gap_shadow = wdata[VALUE_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_gap_limit(input logic [VALUE_W-1:0] want);
        logic [APB_DATA_W-1:0] rdata;
        apb_transfer(1'b0, '0, rdata);
        check_field("gap_limit", int'(want), int'(rdata));
    endtask

    task automatic set_gap_limit(input logic [VALUE_W-1:0] limit);
        logic [APB_DATA_W-1:0] rdata;
        apb_transfer(1'b1, APB_DATA_W'(limit), rdata);
        read_gap_limit(limit);
    endtask

    task automatic test_register_access();
        read_gap_limit(GAP_LIMIT_RESET);
        set_gap_limit(16'd0);
        set_gap_limit(16'hFFFF);
        set_gap_limit(16'h5AA5);
        set_gap_limit(GAP_LIMIT_RESET);
    endtask

    task automatic test_value_extremes();
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd100);
        send_sample(16'd201);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        wait_for_drain();
    endtask

    task automatic test_gap_zero();
        set_gap_limit(16'd0);
        send_sample(16'd500);
        send_sample(16'd500);
        send_sample(16'd501);
        send_sample(16'd499);
        send_sample(16'd500);
        wait_for_drain();
    endtask

    task automatic test_gap_max();
        set_gap_limit(16'hFFFF);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd12345);
        wait_for_drain();
    endtask

    task automatic test_output_backpressure();
        set_gap_limit(GAP_LIMIT_RESET);
        hold_request = 600;
        repeat (10) send_sample(16'($urandom_range(0, 65535)));
        wait_for_drain();
    endtask

    task automatic test_random_clusters(input int count, input int gap_lo, input int gap_hi);
        int                 centers [4];
        int                 gap;
        int                 spread;
        int                 pick;
        int                 v;
        logic [VALUE_W-1:0] last_value;
        gap = $urandom_range(gap_hi, gap_lo);
        set_gap_limit(gap[VALUE_W-1:0]);
        spread = (gap < 8) ? 24 : ((gap > 8000) ? 65535 : gap * 3);
        foreach (centers[k])
            centers[k] = $urandom_range(0, 65535);
        last_value = '0;
        repeat (count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                v = centers[$urandom_range(0, 3)] + $urandom_range(0, spread);
            else if (pick < 8)
                v = last_value;
            else
                v = $urandom_range(0, 65535);
            last_value = v[VALUE_W-1:0];
            send_sample(v[VALUE_W-1:0]);
        end
        wait_for_drain();
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $error("%0d predicted results never arrived", pending_verdicts.size());
            fail_count++;
        end
    endtask

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_value_extremes();
        test_gap_zero();
        test_gap_max();
        test_output_backpressure();
        test_random_clusters(320, 0, 50);
        test_random_clusters(320, 51, 1500);
        test_random_clusters(320, 1501, 20000);
        test_random_clusters(320, 0, 65535);
        quiet_mode = 1'b1;
        test_random_clusters(250, 0, 400);
        finish_run();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/gcfc_pkg.sv
hdl/gcfc_regs.sv
hdl/gcfc_ctrl.sv
hdl/gcfc_dp.sv
hdl/gap_cluster_frequency_classifier.sv
verif/tb_top.sv
